### sv/tspt_pkg.sv
package tspt_pkg;

   localparam logic [1:0] STATUS_TIMED  = 2'd0;
   localparam logic [1:0] STATUS_MASKED = 2'd1;
   localparam logic [1:0] STATUS_CUT    = 2'd2;

   localparam logic KIND_HIT     = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // register index, taken from csr_paddr[2]
   localparam logic CSR_GAIN_MODE = 1'b0;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 56;

   // shape constants: 1/n in Q0.16, 25*wc/(n*ln2) in Q.16
   localparam logic [15:0] INVN_HIGH = 16'd36449;
   localparam logic [15:0] INVN_LOW  = 16'd32508;
   localparam logic signed [21:0] KC_HIGH = 22'sd95850;
   localparam logic signed [21:0] KC_LOW  = 22'sd98167;

   localparam logic signed [16:0] T_ZERO_A2   = 17'sd1280;
   localparam logic signed [16:0] T_MAX       = 17'sd65535;
   localparam logic signed [16:0] T_MIN       = -17'sd65536;
   localparam logic signed [18:0] T_BASE      = 19'sd1280;
   localparam logic [17:0]        Q_LIMIT     = 18'd200000;
   localparam logic signed [16:0] RANGE_LIM   = 17'sd1312;
   localparam logic [6:0]         BIN_UNDER   = 7'd0;
   localparam logic [6:0]         BIN_OVER    = 7'd82;
   localparam logic [6:0]         BIN_MULT    = 7'd81;
   // floor(y/41) for y < 3321
   localparam logic [11:0]        BIN_RECIP   = 12'd3197;
   localparam int                 BIN_SHIFT   = 17;
   localparam logic [11:0]        A1_MIN      = 12'd200;

   localparam int DIV_NUM_W = 42;
   localparam int DIV_DEN_W = 34;
   localparam logic [33:0] C_ONE = 34'h0_4000_0000;
   localparam logic [41:0] Q_NUMERATOR = 42'd1600 << 30;

   typedef struct packed {
      logic              side;
      logic              plane;
      logic signed [12:0] a1;
      logic signed [12:0] a2;
      logic [1:0]        status;
      logic              last;
   } hit_entry_type;

   typedef struct packed {
      logic              kind;
      logic [1:0]        status;
      logic signed [16:0] arrival;
      logic [6:0]        bin;
      logic [1:0]        hsel;
      logic signed [11:0] mean_neg;
      logic signed [11:0] mean_pos;
      logic              pair;
      logic              last;
   } result_type;

   typedef logic [31:0] factor_table_type [16];

   function automatic logic [63:0] isqrt64(logic [63:0] x);
      logic [63:0] res;
      logic [63:0] bt;
      logic [63:0] v;
      res = '0;
      bt  = 64'd1 << 62;
      v   = x;
      while (bt > v) bt = bt >> 2;
      while (bt != 0) begin
         if (v >= res + bt) begin
            v   = v - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      return res;
   endfunction

   // 2^(2^-k) in Q.30 for k = 1..16
   function automatic factor_table_type make_exp_factors();
      factor_table_type tab;
      logic [63:0] r;
      r = isqrt64(64'd1 << 61);
      for (int k = 0; k < 16; k++) begin
         tab[k] = r[31:0];
         r = isqrt64(r << 30);
      end
      return tab;
   endfunction

   localparam factor_table_type EXP_FACTOR = make_exp_factors();

   function automatic logic [3:0] msb_pos(logic [11:0] x);
      logic [3:0] p;
      p = '0;
      for (int i = 0; i < 12; i++) begin
         if (x[i]) p = 4'(i);
      end
      return p;
   endfunction

endpackage

### sv/tspt_front.sv
module tspt_front
   import tspt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   output logic                  q_valid,
   output hit_entry_type         q_entry,
   input  logic                  q_pop
);

   hit_entry_type entry_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;

   logic              side, plane;
   logic [5:0]        sx, sy, st;
   logic signed [12:0] a0, a1, a2;
   logic              masked, cut, push;
   hit_entry_type     new_entry;

   assign side  = req_tdata[0];
   assign plane = req_tdata[1];
   assign sx    = req_tdata[7:2];
   assign sy    = req_tdata[13:8];
   assign st    = req_tdata[19:14];
   assign a0    = req_tdata[32:20];
   assign a1    = req_tdata[45:33];
   assign a2    = req_tdata[58:46];

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;

   always_comb begin
      masked = (!side && !plane && sx == 6'd7 && sy == 6'd28) ||
               (!side && !plane && sx == 6'd24 && sy == 6'd9 && st == 6'd21) ||
               (side && plane && sx == 6'd35 && sy == 6'd17 && st == 6'd23);
      cut    = (a1 < $signed({1'b0, A1_MIN})) || (a0 > 13'sd10) || (a0 < -13'sd10) ||
               (a2 < 13'sd0) || (a0 > a1) || (a0 > a2) || (a2 > a1);
      new_entry.side  = side;
      new_entry.plane = plane;
      new_entry.a1    = a1;
      new_entry.a2    = a2;
      new_entry.last  = req_tlast;
      priority if (masked) new_entry.status = STATUS_MASKED;
      else if (cut)        new_entry.status = STATUS_CUT;
      else                 new_entry.status = STATUS_TIMED;
   end

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= new_entry;
   end

   assign q_valid = (count_ff != 2'd0);
   assign q_entry = entry_ff[rd_ptr_ff];

endmodule

### sv/tspt_div.sv
module tspt_div
   import tspt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] num,
   input  logic [DIV_DEN_W-1:0] den,
   output logic                 done,
   output logic [DIV_NUM_W-1:0] quo
);

   localparam int CNT_W = $clog2(DIV_NUM_W);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W:0]   trial;
   logic                 fits;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_NUM_W-1]};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         den_in  = den;
         rem_in  = '0;
         quo_in  = num;
      end else if (busy_ff) begin
         rem_in = fits ? DIV_DEN_W'(trial - {1'b0, den_ff}) : trial[DIV_DEN_W-1:0];
         quo_in = {quo_ff[DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

### sv/tspt_back.sv
module tspt_back
   import tspt_pkg::*;
#(
   parameter int MAX_HITS = 4096
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          gain_mode,
   input  logic          q_valid,
   input  hit_entry_type q_entry,
   output logic          q_pop,
   output logic          out_valid,
   input  logic          out_ready,
   output result_type    out_result
);

   localparam int CNT_W = $clog2(MAX_HITS + 1);
   localparam int SUM_W = $clog2(MAX_HITS * 1312 + 1) + 1;

   typedef enum logic [14:0] {
      S_IDLE     = 15'b000000000000001,
      S_LOG      = 15'b000000000000010,
      S_EXPW     = 15'b000000000000100,
      S_EXP      = 15'b000000000001000,
      S_SHIFT    = 15'b000000000010000,
      S_QDIV     = 15'b000000000100000,
      S_QWAIT    = 15'b000000001000000,
      S_BIN      = 15'b000000010000000,
      S_BIN2     = 15'b000000100000000,
      S_EMIT_HIT = 15'b000001000000000,
      S_MNEG     = 15'b000010000000000,
      S_MNEG_W   = 15'b000100000000000,
      S_MPOS     = 15'b001000000000000,
      S_MPOS_W   = 15'b010000000000000,
      S_EMIT_SUM = 15'b100000000000000
   } back_state_type;

   back_state_type     state_ff, state_in;
   hit_entry_type      entry_ff, entry_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic [15:0]        m1_ff, m1_in, m2_ff, m2_in;
   logic [15:0]        f1_ff, f1_in, f2_ff, f2_in;
   logic [3:0]         p1_ff, p1_in, p2_ff, p2_in;
   logic signed [21:0] e_ff, e_in;
   logic [31:0]        mexp_ff, mexp_in;
   logic [33:0]        c_ff, c_in;
   logic signed [16:0] t_ff, t_in;
   logic [17:0]        xs_ff, xs_in;
   logic [6:0]         bin_ff, bin_in;
   logic signed [11:0] mneg_ff, mneg_in, mpos_ff, mpos_in;

   logic signed [SUM_W-1:0] sum_pos_ff, sum_pos_in, sum_neg_ff, sum_neg_in;
   logic [CNT_W-1:0] cnt_pos_ff, cnt_pos_in, cnt_neg_ff, cnt_neg_in;
   logic [CNT_W-1:0] ent_pos_ff, ent_pos_in, ent_neg_ff, ent_neg_in;

   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;

   logic                 div_start, div_done;
   logic [DIV_NUM_W-1:0] div_num, div_quo;
   logic [DIV_DEN_W-1:0] div_den;

   logic [31:0]        sq1, sq2;
   logic [16:0]        s1, s2;
   logic signed [20:0] dlog;
   logic [19:0]        dabs;
   logic [35:0]        dprod;
   logic [36:0]        dround;
   logic [20:0]        em;
   logic [63:0]        eprod;
   logic signed [5:0]  ip;
   logic [5:0]         ip_mag;
   logic [33:0]        mwide;
   logic               c_below;
   logic [33:0]        cden;
   logic [17:0]        qc;
   logic signed [18:0] t19;
   logic signed [17:0] tx;
   logic               t_in_range;
   logic [23:0]        bprod;
   logic [SUM_W-1:0]   abs_neg, abs_pos;
   logic               out_free;

   tspt_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      sq1 = m1_ff * m1_ff;
      sq2 = m2_ff * m2_ff;
      s1  = sq1[31:15];
      s2  = sq2[31:15];

      dlog   = $signed({1'b0, p2_ff, f2_ff}) - $signed({1'b0, p1_ff, f1_ff});
      dabs   = dlog[20] ? 20'(-dlog) : dlog[19:0];
      dprod  = dabs * (gain_mode ? INVN_LOW : INVN_HIGH);
      dround = {1'b0, dprod} + 37'd32768;
      em     = dround[36:16];

      eprod  = mexp_ff * EXP_FACTOR[cnt_ff];
      ip     = e_ff[21:16];
      ip_mag = 6'(-ip);
      mwide  = {2'b00, mexp_ff};

      c_below = c_ff < C_ONE;
      cden    = c_below ? C_ONE - c_ff : c_ff - C_ONE;
      qc      = (div_quo > DIV_NUM_W'(Q_LIMIT)) ? Q_LIMIT : div_quo[17:0];
      t19     = c_below ? T_BASE + $signed({1'b0, qc}) : T_BASE - $signed({1'b0, qc});

      t_in_range = (t_ff >= -RANGE_LIM) && (t_ff < RANGE_LIM);
      tx         = $signed({t_ff[16], t_ff}) + 18'sd1312;
      bprod      = xs_ff[17:6] * BIN_RECIP;

      abs_neg = sum_neg_ff[SUM_W-1] ? SUM_W'(-sum_neg_ff) : sum_neg_ff;
      abs_pos = sum_pos_ff[SUM_W-1] ? SUM_W'(-sum_pos_ff) : sum_pos_ff;
      out_free = !out_valid_ff || out_ready;
   end

   always_comb begin
      state_in   = state_ff;
      entry_in   = entry_ff;
      cnt_in     = cnt_ff;
      m1_in      = m1_ff;
      m2_in      = m2_ff;
      f1_in      = f1_ff;
      f2_in      = f2_ff;
      p1_in      = p1_ff;
      p2_in      = p2_ff;
      e_in       = e_ff;
      mexp_in    = mexp_ff;
      c_in       = c_ff;
      t_in       = t_ff;
      xs_in      = xs_ff;
      bin_in     = bin_ff;
      mneg_in    = mneg_ff;
      mpos_in    = mpos_ff;
      sum_pos_in = sum_pos_ff;
      sum_neg_in = sum_neg_ff;
      cnt_pos_in = cnt_pos_ff;
      cnt_neg_in = cnt_neg_ff;
      ent_pos_in = ent_pos_ff;
      ent_neg_in = ent_neg_ff;
      out_in     = out_ff;
      out_valid_in = out_valid_ff && !out_ready;
      q_pop      = 1'b0;
      div_start  = 1'b0;
      div_num    = DIV_NUM_W'(Q_NUMERATOR + DIV_NUM_W'(cden >> 1));
      div_den    = cden;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               entry_in = q_entry;
               t_in     = '0;
               bin_in   = BIN_UNDER;
               cnt_in   = '0;
               p1_in    = msb_pos(q_entry.a1[11:0]);
               p2_in    = msb_pos(q_entry.a2[11:0]);
               m1_in    = 16'({4'b0, q_entry.a1[11:0]} << (4'd15 - msb_pos(q_entry.a1[11:0])));
               m2_in    = 16'({4'b0, q_entry.a2[11:0]} << (4'd15 - msb_pos(q_entry.a2[11:0])));
               f1_in    = '0;
               f2_in    = '0;
               priority if (q_entry.status != STATUS_TIMED) begin
                  state_in = S_EMIT_HIT;
               end else if (q_entry.a2 == 13'sd0) begin
                  t_in     = T_ZERO_A2;
                  state_in = S_BIN;
               end else begin
                  state_in = S_LOG;
               end
            end
         end
         S_LOG: begin
            // mantissa squaring, one result bit of each log per cycle
            m1_in  = s1[16] ? s1[16:1] : s1[15:0];
            m2_in  = s2[16] ? s2[16:1] : s2[15:0];
            f1_in  = {f1_ff[14:0], s1[16]};
            f2_in  = {f2_ff[14:0], s2[16]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 4'd15) state_in = S_EXPW;
         end
         S_EXPW: begin
            if (dlog <= 21'sd0) e_in = (gain_mode ? KC_LOW : KC_HIGH) - $signed({1'b0, em});
            else                e_in = (gain_mode ? KC_LOW : KC_HIGH) + $signed({1'b0, em});
            mexp_in  = 32'h4000_0000;
            cnt_in   = '0;
            state_in = S_EXP;
         end
         S_EXP: begin
            if (e_ff[4'd15 - cnt_ff]) mexp_in = eprod[61:30];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 4'd15) state_in = S_SHIFT;
         end
         S_SHIFT: begin
            if (!ip[5]) c_in = mwide << ((ip > 6'sd2) ? 6'd2 : ip_mag == 6'd0 ? 6'd0 : 6'(ip));
            else        c_in = mwide >> ip_mag;
            state_in = S_QDIV;
         end
         S_QDIV: begin
            if (c_ff == C_ONE) begin
               t_in     = T_MAX;
               state_in = S_BIN;
            end else begin
               div_start = 1'b1;
               state_in  = S_QWAIT;
            end
         end
         S_QWAIT: begin
            if (div_done) begin
               priority if (t19 > 19'sd65535) t_in = T_MAX;
               else if (t19 < -19'sd65536)     t_in = T_MIN;
               else                            t_in = t19[16:0];
               state_in = S_BIN;
            end
         end
         S_BIN: begin
            xs_in    = 18'(tx[11:0]) * 18'(BIN_MULT);
            state_in = S_BIN2;
         end
         S_BIN2: begin
            priority if (t_ff < -RANGE_LIM) bin_in = BIN_UNDER;
            else if (t_ff >= RANGE_LIM)     bin_in = BIN_OVER;
            else                            bin_in = 7'(bprod >> BIN_SHIFT) + 7'd1;
            if (!entry_ff.side) begin
               if (ent_pos_ff < CNT_W'(MAX_HITS)) begin
                  ent_pos_in = ent_pos_ff + 1'b1;
                  if (t_in_range) begin
                     sum_pos_in = sum_pos_ff + SUM_W'(t_ff);
                     cnt_pos_in = cnt_pos_ff + 1'b1;
                  end
               end
            end else begin
               if (ent_neg_ff < CNT_W'(MAX_HITS)) begin
                  ent_neg_in = ent_neg_ff + 1'b1;
                  if (t_in_range) begin
                     sum_neg_in = sum_neg_ff + SUM_W'(t_ff);
                     cnt_neg_in = cnt_neg_ff + 1'b1;
                  end
               end
            end
            state_in = S_EMIT_HIT;
         end
         S_EMIT_HIT: begin
            if (out_free) begin
               out_valid_in     = 1'b1;
               out_in.kind      = KIND_HIT;
               out_in.status    = entry_ff.status;
               out_in.arrival   = t_ff;
               out_in.bin       = bin_ff;
               out_in.hsel      = {entry_ff.side, entry_ff.plane};
               out_in.mean_neg  = '0;
               out_in.mean_pos  = '0;
               out_in.pair      = 1'b0;
               out_in.last      = !entry_ff.last;
               state_in = entry_ff.last ? S_MNEG : S_IDLE;
            end
         end
         S_MNEG: begin
            div_num = DIV_NUM_W'(abs_neg) + DIV_NUM_W'(cnt_neg_ff >> 1);
            div_den = DIV_DEN_W'(cnt_neg_ff);
            if (cnt_neg_ff == '0) begin
               mneg_in  = '0;
               state_in = S_MPOS;
            end else begin
               div_start = 1'b1;
               state_in  = S_MNEG_W;
            end
         end
         S_MNEG_W: begin
            if (div_done) begin
               mneg_in  = sum_neg_ff[SUM_W-1] ? -$signed(div_quo[11:0]) : $signed(div_quo[11:0]);
               state_in = S_MPOS;
            end
         end
         S_MPOS: begin
            div_num = DIV_NUM_W'(abs_pos) + DIV_NUM_W'(cnt_pos_ff >> 1);
            div_den = DIV_DEN_W'(cnt_pos_ff);
            if (cnt_pos_ff == '0) begin
               mpos_in  = '0;
               state_in = S_EMIT_SUM;
            end else begin
               div_start = 1'b1;
               state_in  = S_MPOS_W;
            end
         end
         S_MPOS_W: begin
            if (div_done) begin
               mpos_in  = sum_pos_ff[SUM_W-1] ? -$signed(div_quo[11:0]) : $signed(div_quo[11:0]);
               state_in = S_EMIT_SUM;
            end
         end
         S_EMIT_SUM: begin
            if (out_free) begin
               out_valid_in     = 1'b1;
               out_in.kind      = KIND_SUMMARY;
               out_in.status    = STATUS_TIMED;
               out_in.arrival   = '0;
               out_in.bin       = '0;
               out_in.hsel      = '0;
               out_in.mean_neg  = mneg_ff;
               out_in.mean_pos  = mpos_ff;
               out_in.pair      = (ent_pos_ff != '0) && (ent_neg_ff != '0);
               out_in.last      = 1'b1;
               sum_pos_in = '0;
               sum_neg_in = '0;
               cnt_pos_in = '0;
               cnt_neg_in = '0;
               ent_pos_in = '0;
               ent_neg_in = '0;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         sum_pos_ff   <= '0;
         sum_neg_ff   <= '0;
         cnt_pos_ff   <= '0;
         cnt_neg_ff   <= '0;
         ent_pos_ff   <= '0;
         ent_neg_ff   <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         sum_pos_ff   <= sum_pos_in;
         sum_neg_ff   <= sum_neg_in;
         cnt_pos_ff   <= cnt_pos_in;
         cnt_neg_ff   <= cnt_neg_in;
         ent_pos_ff   <= ent_pos_in;
         ent_neg_ff   <= ent_neg_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      m1_ff    <= m1_in;
      m2_ff    <= m2_in;
      f1_ff    <= f1_in;
      f2_ff    <= f2_in;
      p1_ff    <= p1_in;
      p2_ff    <= p2_in;
      e_ff     <= e_in;
      mexp_ff  <= mexp_in;
      c_ff     <= c_in;
      t_ff     <= t_in;
      xs_ff    <= xs_in;
      bin_ff   <= bin_in;
      mneg_ff  <= mneg_in;
      mpos_ff  <= mpos_in;
      out_ff   <= out_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_result = out_ff;

endmodule

### sv/three_sample_pulse_timing.sv
// channel  | direction | handshake             | payload
// req      | in        | req_tvalid/req_tready | req_tdata hit fields, req_tlast event end
// rsp      | out       | rsp_tvalid/rsp_tready | rsp_tdata result, rsp_tuser kind, rsp_tlast
// csr      | in        | APB write/read        | gain_mode at byte address 0
//
// From acceptance to a valid result, a masked or cut hit goes straight to emission, a timed
// hit with a zero third sample passes through the two bin states, and any other timed hit
// also runs two 16-step loops (log2 squaring, exp2 factor products) and, unless c is one,
// a 42-bit quotient on the shared restoring divider. The summary follows the event-ending
// hit result, after the two side means on the same divider and the emit state.
// Reset is synchronous and clears all control and accumulators.
// A two-entry queue takes hits while the back end works, and the result register
// lets the back end finish while rsp is stalled.
module three_sample_pulse_timing
   import tspt_pkg::*;
#(
   parameter int MAX_HITS_PER_EVENT = 4096
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // side_negative, plane_index, sensor_x, sensor_y, strip_number,
   // sample_first, sample_second, sample_third
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // hit_status, arrival_time, time_bin, histogram_select, mean_negative,
   // mean_positive, pair_valid
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // result_kind
   output logic                  rsp_tuser,
   output logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic          gain_mode_ff, gain_mode_in;
   logic          q_valid, q_pop;
   hit_entry_type q_entry;
   result_type    res;

   assign csr_pready = 1'b1;

   always_comb begin
      gain_mode_in = gain_mode_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == CSR_GAIN_MODE)
         gain_mode_in = csr_pwdata[0];
      csr_prdata = (csr_paddr[2] == CSR_GAIN_MODE) ? {31'b0, gain_mode_ff} : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) gain_mode_ff <= 1'b0;
      else       gain_mode_ff <= gain_mode_in;
   end

   tspt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop)
   );

   tspt_back #(
      .MAX_HITS (MAX_HITS_PER_EVENT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .gain_mode  (gain_mode_ff),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (res)
   );

   assign rsp_tdata = {3'b000, res.pair, res.mean_pos, res.mean_neg, res.hsel,
                       res.bin, res.arrival, res.status};
   assign rsp_tuser = res.kind;
   assign rsp_tlast = res.last;

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import tspt_pkg::*;

   localparam int HIT_CAP    = 4096;
   localparam int CYCLE_CAP  = 3000000;
   localparam longint unsigned Q30_ONE = 64'd1 << 30;

   typedef struct {
      logic              side;
      logic              plane;
      logic [5:0]        sx;
      logic [5:0]        sy;
      logic [5:0]        strip;
      logic signed [12:0] a0;
      logic signed [12:0] a1;
      logic signed [12:0] a2;
      logic              event_end;
   } strip_hit_type;

   typedef struct {
      logic              kind;
      logic [1:0]        status;
      logic signed [16:0] arrival;
      logic [6:0]        bin;
      logic [1:0]        hsel;
      logic signed [11:0] mean_neg;
      logic signed [11:0] mean_pos;
      logic              pair;
      logic              last;
   } timing_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   three_sample_pulse_timing u_top (.*);

   always #5 clock = ~clock;

   // predictor state
   logic   model_gain;
   longint sum_pos, sum_neg;
   int     cnt_pos_in, cnt_neg_in, hits_pos, hits_neg;

   timing_result_type pending_results[$];
   int  error_count = 0;
   int  send_idle_pct = 0;
   int  rsp_idle_pct = 0;
   int  stall_left = 0;
   longint cycle_count = 0;

   function automatic longint unsigned int_root(longint unsigned x);
      longint unsigned acc, b, v;
      acc = 0;
      b = 64'd1 << 62;
      v = x;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= acc + b) begin
            v = v - (acc + b);
            acc = (acc >> 1) + b;
         end else begin
            acc = acc >> 1;
         end
         b = b >> 2;
      end
      return acc;
   endfunction

   // log2 in Q.16 by repeated squaring of the mantissa
   function automatic longint log2_fix(int x);
      int p;
      longint unsigned m, frac;
      p = 0;
      frac = 0;
      if (x == 0) return 0;
      while ((x >> (p + 1)) != 0) p++;
      m = longint'(x) << (15 - p);
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 15;
         frac = frac << 1;
         if (m >= 64'd65536) begin
            m = m >> 1;
            frac = frac | 1;
         end
      end
      return (longint'(p) << 16) | longint'(frac);
   endfunction

   // 2^e, e in Q.16, result in Q.30
   function automatic longint unsigned pow2_fix(longint e);
      longint ip;
      longint unsigned fbits, r, m;
      ip = e >>> 16;
      fbits = e & 64'hFFFF;
      r = int_root(64'd1 << 61);
      m = Q30_ONE;
      for (int k = 1; k <= 16; k++) begin
         if (((fbits >> (16 - k)) & 1) != 0) m = (m * r) >> 30;
         r = int_root(r << 30);
      end
      if (ip >= 0) return (ip > 2) ? (m << 2) : (m << ip);
      return (ip < -40) ? 64'd0 : (m >> (-ip));
   endfunction

   function automatic int arrival_fix(int a1, int a2, logic low_gain);
      longint invn, kc, d, em, e, t;
      longint unsigned c, den, q;
      invn = low_gain ? 32508 : 36449;
      kc = low_gain ? 98167 : 95850;
      if (a2 == 0) return 1280;
      d = log2_fix(a2) - log2_fix(a1);
      if (d <= 0) begin
         em = ((-d) * invn + 32768) >>> 16;
         e = kc - em;
      end else begin
         em = (d * invn + 32768) >>> 16;
         e = kc + em;
      end
      c = pow2_fix(e);
      if (c == Q30_ONE) return 65535;
      den = (c < Q30_ONE) ? Q30_ONE - c : c - Q30_ONE;
      q = (64'd1600 * Q30_ONE + den / 2) / den;
      if (q > 200000) q = 200000;
      t = (c < Q30_ONE) ? 1280 + longint'(q) : 1280 - longint'(q);
      if (t > 65535) t = 65535;
      if (t < -65536) t = -65536;
      return int'(t);
   endfunction

   function automatic longint side_mean(longint s, int n);
      longint c;
      c = n;
      if (n == 0) return 0;
      if (s >= 0) return (s + c / 2) / c;
      return -((-s + c / 2) / c);
   endfunction

   function automatic logic is_dead_channel(strip_hit_type h);
      return (!h.side && !h.plane && h.sx == 7 && h.sy == 28) ||
             (!h.side && !h.plane && h.sx == 24 && h.sy == 9 && h.strip == 21) ||
             (h.side && h.plane && h.sx == 35 && h.sy == 17 && h.strip == 23);
   endfunction

   task automatic predict_timing(strip_hit_type h);
      timing_result_type r, s;
      int  t, a0, a1, a2;
      logic in_range;
      a0 = h.a0;
      a1 = h.a1;
      a2 = h.a2;
      r = '{default: '0};
      r.kind = KIND_HIT;
      r.hsel = {h.side, h.plane};
      r.last = !h.event_end;
      if (is_dead_channel(h)) r.status = STATUS_MASKED;
      else if (a1 < 200 || a0 > 10 || a0 < -10 || a2 < 0 || a0 > a1 || a0 > a2 || a2 > a1)
         r.status = STATUS_CUT;
      else begin
         r.status = STATUS_TIMED;
         t = arrival_fix(a1, a2, model_gain);
         r.arrival = 17'(t);
         in_range = (t >= -1312 && t < 1312);
         if (t < -1312) r.bin = BIN_UNDER;
         else if (t >= 1312) r.bin = BIN_OVER;
         else r.bin = 7'(((t + 1312) * 81) / (41 * 64) + 1);
         if (!h.side) begin
            if (hits_pos < HIT_CAP) begin
               hits_pos++;
               if (in_range) begin
                  sum_pos += t;
                  cnt_pos_in++;
               end
            end
         end else if (hits_neg < HIT_CAP) begin
            hits_neg++;
            if (in_range) begin
               sum_neg += t;
               cnt_neg_in++;
            end
         end
      end
      pending_results.push_back(r);
      if (h.event_end) begin
         s = '{default: '0};
         s.kind = KIND_SUMMARY;
         s.mean_neg = 12'(side_mean(sum_neg, cnt_neg_in));
         s.mean_pos = 12'(side_mean(sum_pos, cnt_pos_in));
         s.pair = (hits_pos > 0 && hits_neg > 0);
         s.last = 1'b1;
         pending_results.push_back(s);
         sum_pos = 0;
         sum_neg = 0;
         cnt_pos_in = 0;
         cnt_neg_in = 0;
         hits_pos = 0;
         hits_neg = 0;
      end
   endtask

   // called at a falling edge; returns at a falling edge
   task automatic send_hit(strip_hit_type h);
      req_tvalid = 1'b1;
      req_tlast = h.event_end;
      req_tdata = {5'b0, h.a2, h.a1, h.a0, h.strip, h.sy, h.sx, h.plane, h.side};
      do @(posedge clock); while (!req_tready);
      predict_timing(h);
      @(negedge clock);
      req_tvalid = 1'b0;
      if ($urandom_range(99) < send_idle_pct) repeat ($urandom_range(4, 1)) @(negedge clock);
   endtask

   task automatic write_gain(logic g);
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_paddr = {CSR_GAIN_MODE, 2'b00};
      csr_pwdata = {31'b0, g};
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      model_gain = g;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   function automatic strip_hit_type make_hit(int side, int plane, int sx, int sy, int st,
                                              int a0, int a1, int a2, int last);
      strip_hit_type h;
      h.side = 1'(side);
      h.plane = 1'(plane);
      h.sx = 6'(sx);
      h.sy = 6'(sy);
      h.strip = 6'(st);
      h.a0 = 13'(a0);
      h.a1 = 13'(a1);
      h.a2 = 13'(a2);
      h.event_end = 1'(last);
      return h;
   endfunction

   function automatic strip_hit_type good_hit();
      strip_hit_type h;
      int a0, a1, lo;
      a0 = int'($urandom_range(20)) - 10;
      a1 = $urandom_range(4095, 200);
      lo = (a0 > 0) ? a0 : 0;
      h = make_hit($urandom_range(1), $urandom_range(1), $urandom_range(63),
                   $urandom_range(63), $urandom_range(63), a0, a1, 0, 0);
      // some near A2/A1 ~ 1/6 where c approaches one
      if ($urandom_range(3) == 0 && a1 / 6 >= lo)
         h.a2 = 13'($urandom_range(a1 / 5, a1 / 7 > lo ? a1 / 7 : lo));
      else h.a2 = 13'($urandom_range(a1, lo));
      if (is_dead_channel(h)) h.sx = 0;
      return h;
   endfunction

   function automatic strip_hit_type random_hit();
      strip_hit_type h;
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) h = good_hit();
      else begin
         h.side = 1'($urandom_range(1));
         h.plane = 1'($urandom_range(1));
         h.sx = 6'($urandom_range(63));
         h.sy = 6'($urandom_range(63));
         h.strip = 6'($urandom_range(63));
         h.a0 = 13'($urandom_range(8191));
         h.a1 = 13'($urandom_range(8191));
         h.a2 = 13'($urandom_range(8191));
         if (pick < 80) h = make_hit(1, 1, 35, 17, 23, h.a0, h.a1, h.a2, 0);
         else if (pick < 85) h = make_hit(0, 0, 7, 28, h.strip, h.a0, h.a1, h.a2, 0);
         else if (pick < 88) h = make_hit(0, 0, 24, 9, 21, h.a0, h.a1, h.a2, 0);
      end
      h.event_end = ($urandom_range(5) == 0);
      return h;
   endfunction

   task automatic test_directed();
      strip_hit_type dir[$];
      dir.push_back(make_hit(0, 0, 7, 28, 0, 0, 1000, 500, 0));
      dir.push_back(make_hit(0, 0, 7, 28, 63, 0, 1000, 500, 0));
      dir.push_back(make_hit(0, 0, 24, 9, 21, 0, 1000, 500, 0));
      dir.push_back(make_hit(1, 1, 35, 17, 23, 0, 1000, 500, 0));
      dir.push_back(make_hit(1, 1, 35, 17, 22, 0, 1000, 500, 0));
      dir.push_back(make_hit(0, 1, 1, 1, 1, 0, 199, 100, 0));
      dir.push_back(make_hit(1, 0, 40, 40, 32, 11, 1000, 500, 0));
      dir.push_back(make_hit(1, 0, 40, 40, 32, -11, 1000, 500, 0));
      dir.push_back(make_hit(0, 1, 1, 40, 1, 0, 1000, -1, 0));
      dir.push_back(make_hit(0, 1, 1, 40, 1, 5, 1000, 3, 0));
      dir.push_back(make_hit(0, 1, 1, 40, 1, 0, 1000, 1001, 0));
      dir.push_back(make_hit(1, 1, 2, 2, 2, -4096, 4095, -4096, 0));
      dir.push_back(make_hit(1, 1, 2, 2, 2, 4095, -4096, 4095, 0));
      dir.push_back(make_hit(0, 0, 3, 3, 3, -10, 600, 0, 0));
      dir.push_back(make_hit(0, 0, 3, 3, 3, 10, 4095, 4095, 0));
      dir.push_back(make_hit(1, 0, 3, 3, 3, 0, 200, 200, 0));
      dir.push_back(make_hit(1, 0, 3, 3, 3, 0, 1240, 200, 0));
      dir.push_back(make_hit(0, 1, 3, 3, 3, 0, 4095, 1, 0));
      dir.push_back(make_hit(1, 1, 3, 3, 3, 0, 1000, 170, 1));
      dir.push_back(make_hit(0, 0, 5, 5, 5, 0, 3000, 2000, 1));
      dir.push_back(make_hit(0, 0, 7, 28, 5, 0, 3000, 2000, 1));
      foreach (dir[i]) send_hit(dir[i]);
   endtask

   task automatic test_random_phase(int n_hits, int send_pct, int rsp_pct);
      send_idle_pct = send_pct;
      rsp_idle_pct = rsp_pct;
      repeat (n_hits) send_hit(random_hit());
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      @(posedge clock);
      stall_left = 3000;
      @(negedge clock);
      repeat (12) send_hit(good_hit());
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      timing_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result transaction");
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.kind) begin
               $error("result_kind: expected %0d, got %0d", want.kind, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[1:0] !== want.status) begin
               $error("hit_status: expected %0d, got %0d", want.status, rsp_tdata[1:0]);
               error_count++;
            end
            if (rsp_tdata[18:2] !== want.arrival) begin
               $error("arrival_time: expected %0d, got %0d", want.arrival,
                      $signed(rsp_tdata[18:2]));
               error_count++;
            end
            if (rsp_tdata[25:19] !== want.bin) begin
               $error("time_bin: expected %0d, got %0d", want.bin, rsp_tdata[25:19]);
               error_count++;
            end
            if (rsp_tdata[27:26] !== want.hsel) begin
               $error("histogram_select: expected %0d, got %0d", want.hsel, rsp_tdata[27:26]);
               error_count++;
            end
            if (rsp_tdata[39:28] !== want.mean_neg) begin
               $error("mean_negative: expected %0d, got %0d", want.mean_neg,
                      $signed(rsp_tdata[39:28]));
               error_count++;
            end
            if (rsp_tdata[51:40] !== want.mean_pos) begin
               $error("mean_positive: expected %0d, got %0d", want.mean_pos,
                      $signed(rsp_tdata[51:40]));
               error_count++;
            end
            if (rsp_tdata[52] !== want.pair) begin
               $error("pair_valid: expected %0d, got %0d", want.pair, rsp_tdata[52]);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_result: expected %0d, got %0d", want.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      model_gain = 1'b0;
      sum_pos = 0;
      sum_neg = 0;
      cnt_pos_in = 0;
      cnt_neg_in = 0;
      hits_pos = 0;
      hits_neg = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      write_gain(1'b1);
      test_directed();
      test_random_phase(200, 33, 70);
      write_gain(1'b0);
      test_random_phase(200, 70, 33);
      test_backpressure();
      write_gain(1'b1);
      test_random_phase(200, 0, 0);

      while (pending_results.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### three_sample_pulse_timing.f
sv/tspt_pkg.sv
sv/tspt_front.sv
sv/tspt_div.sv
sv/tspt_back.sv
sv/three_sample_pulse_timing.sv
sim/testbench.sv
